// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define CHECK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies an expression in the same cycle.
`define CHECK_SAME(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define CHECK_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

// ===== design/lpvl_pkg.sv =====
// Shared types and constants of the LRU page victim list.
package lpvl_pkg;

    localparam int PAGE_W         = 6;
    localparam int DATA_W         = 8;
    localparam int NUM_FRAMES_DEF = 64;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } state_t;

    typedef enum logic {
        OP_TOUCH  = 1'b0,
        OP_VICTIM = 1'b1
    } op_t;

    typedef struct packed {
        logic rd_en;
        logic next_we;
        logic prev_we;
    } ram_ctl_t;

endpackage

// ===== design/lpvl_link_ram.sv =====
// Link memories: next links, and prev links with the membership flag on top.
module lpvl_link_ram #(
    parameter int NUM_FRAMES = lpvl_pkg::NUM_FRAMES_DEF,
    localparam int IDX_W     = $clog2(NUM_FRAMES)
) (
    input  logic                 clk,
    input  lpvl_pkg::ram_ctl_t   ctl,
    input  logic [IDX_W-1:0]     rd_addr,
    input  logic [IDX_W-1:0]     next_wr_addr,
    input  logic [IDX_W-1:0]     next_wr_data,
    input  logic [IDX_W-1:0]     prev_wr_addr,
    input  logic [IDX_W:0]       prev_wr_data,
    output logic [IDX_W-1:0]     rd_next_reg,
    output logic [IDX_W:0]       rd_prev_reg
);
    import lpvl_pkg::*;

    logic [IDX_W-1:0] next_mem [NUM_FRAMES];
    logic [IDX_W:0]   prev_mem [NUM_FRAMES];

    always_ff @(posedge clk)
    begin
        if (ctl.next_we)
        begin
            next_mem[next_wr_addr] <= next_wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_next_reg <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prev_we)
        begin
            prev_mem[prev_wr_addr] <= prev_wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_prev_reg <= prev_mem[rd_addr];
        end
    end

endmodule

// ===== design/lru_page_victim_list.sv =====
// Top level of the LRU page victim list: recency list held in link memories.
//
//  channel  dir  tdata (low bit up)        tuser
//  s_axis   in   page_id[5:0], pad[7:6]    op (0 touch, 1 victim)
//  m_axis   out  victim_page[5:0], pad     victim_found
//
//  A touch or a victim request on a non-empty list goes through a link read,
//  a first write-back and a second write-back, all through the link memories.
//  An empty-list victim request or an out-of-range touch is handled without leaving the idle state.
//  After reset a sweep over all NUM_FRAMES entries clears the membership flags;
//  s_axis_tready stays low during it.
//  s_axis_tready is also low while an untaken result waits in the output register.
`include "assert_macros.svh"

module lru_page_victim_list #(
    parameter int NUM_FRAMES = lpvl_pkg::NUM_FRAMES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lpvl_pkg::DATA_W-1:0]   s_axis_tdata,   // page_id[5:0], zero pad
    input  logic                          s_axis_tuser,   // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lpvl_pkg::DATA_W-1:0]   m_axis_tdata,   // victim_page[5:0], zero pad
    output logic                          m_axis_tuser    // victim_found
);
    import lpvl_pkg::*;

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);

    state_t             state_reg, state_next;
    op_t                op_reg;
    logic [IDX_W-1:0]   pg_reg;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [IDX_W-1:0]   newest_reg, newest_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   clear_cnt_reg;
    logic               w2n_en_reg, w2n_en_next;
    logic [IDX_W-1:0]   w2n_addr_reg, w2n_addr_next;
    logic [IDX_W:0]     w2p_data_reg, w2p_data_next;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [PAGE_W-1:0]  out_page_reg;

    ram_ctl_t           ram_ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   next_wr_addr, next_wr_data;
    logic [IDX_W-1:0]   prev_wr_addr;
    logic [IDX_W:0]     prev_wr_data;
    logic [IDX_W-1:0]   rd_next_reg;
    logic [IDX_W:0]     rd_prev_reg;

    logic               s_fire;
    logic               in_victim;
    logic               in_range;
    logic [IDX_W-1:0]   page_idx;
    logic               start;
    logic               empty_victim;

    logic               listed;
    logic [IDX_W-1:0]   nx, pv;
    logic               is_old, is_new;
    logic [IDX_W-1:0]   oldest1, newest1;
    logic [CNT_W-1:0]   count1;
    logic               w1n_en, w1p_en;

    assign page_idx     = IDX_W'(s_axis_tdata[PAGE_W-1:0]);
    assign in_range     = 32'(s_axis_tdata[PAGE_W-1:0]) < 32'(NUM_FRAMES);
    assign in_victim    = op_t'(s_axis_tuser) == OP_VICTIM;
    assign s_fire       = s_axis_tvalid && s_axis_tready;
    assign start        = s_fire && (in_victim ? (count_reg != '0) : in_range);
    assign empty_victim = s_fire && in_victim && (count_reg == '0);

    // unlink, then append for a touch; unlink only for a victim
    always_comb
    begin
        listed  = rd_prev_reg[IDX_W];
        pv      = rd_prev_reg[IDX_W-1:0];
        nx      = rd_next_reg;
        is_old  = pg_reg == oldest_reg;
        is_new  = pg_reg == newest_reg;
        oldest1 = (listed && is_old) ? nx : oldest_reg;
        newest1 = (listed && is_new) ? pv : newest_reg;
        count1  = listed ? count_reg - CNT_W'(1) : count_reg;
        w1n_en  = listed && !is_old;
        w1p_en  = listed && !is_new;
        if (op_reg == OP_TOUCH)
        begin
            oldest_next   = (count1 == '0) ? pg_reg : oldest1;
            newest_next   = pg_reg;
            count_next    = count1 + CNT_W'(1);
            w2n_en_next   = count1 != '0;
            w2n_addr_next = newest1;
            w2p_data_next = {1'b1, newest1};
        end
        else
        begin
            oldest_next   = oldest1;
            newest_next   = newest1;
            count_next    = count1;
            w2n_en_next   = 1'b0;
            w2n_addr_next = newest1;
            w2p_data_next = {1'b0, newest1};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_cnt_reg == IDX_W'(NUM_FRAMES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_ctl       = '0;
        rd_addr       = in_victim ? oldest_reg : page_idx;
        next_wr_addr  = pv;
        next_wr_data  = nx;
        prev_wr_addr  = nx;
        prev_wr_data  = {1'b1, pv};
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_ctl.prev_we = 1'b1;
                prev_wr_addr    = clear_cnt_reg;
                prev_wr_data    = '0;
            end
            ST_IDLE:
            begin
                s_axis_tready = !out_valid_reg || m_axis_tready;
                ram_ctl.rd_en = s_fire;
            end
            ST_EXEC:
            begin
                ram_ctl.next_we = w1n_en;
                ram_ctl.prev_we = w1p_en;
            end
            ST_FIN:
            begin
                ram_ctl.next_we = w2n_en_reg;
                ram_ctl.prev_we = 1'b1;
                next_wr_addr    = w2n_addr_reg;
                next_wr_data    = pg_reg;
                prev_wr_addr    = pg_reg;
                prev_wr_data    = w2p_data_reg;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clear_cnt_reg <= clear_cnt_reg + IDX_W'(1);
            end
            if (state_reg == ST_EXEC)
            begin
                oldest_reg <= oldest_next;
                newest_reg <= newest_next;
                count_reg  <= count_next;
            end
            priority if (empty_victim || (state_reg == ST_EXEC && op_reg == OP_VICTIM))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg <= op_t'(s_axis_tuser);
            pg_reg <= rd_addr;
        end
        if (state_reg == ST_EXEC)
        begin
            w2n_en_reg   <= w2n_en_next;
            w2n_addr_reg <= w2n_addr_next;
            w2p_data_reg <= w2p_data_next;
        end
        priority if (empty_victim)
        begin
            out_found_reg <= 1'b0;
            out_page_reg  <= '0;
        end
        else if (state_reg == ST_EXEC && op_reg == OP_VICTIM)
        begin
            out_found_reg <= 1'b1;
            out_page_reg  <= PAGE_W'(pg_reg);
        end
        else
        begin
            out_found_reg <= out_found_reg;
            out_page_reg  <= out_page_reg;
        end
    end

    lpvl_link_ram #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_link_ram (
        .clk          (clk),
        .ctl          (ram_ctl),
        .rd_addr      (rd_addr),
        .next_wr_addr (next_wr_addr),
        .next_wr_data (next_wr_data),
        .prev_wr_addr (prev_wr_addr),
        .prev_wr_data (prev_wr_data),
        .rd_next_reg  (rd_next_reg),
        .rd_prev_reg  (rd_prev_reg)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(DATA_W - PAGE_W){1'b0}}, out_page_reg};

    `CHECK_ALWAYS(a_count_bound, count_reg <= CNT_W'(NUM_FRAMES), "entry count overflow")
    `CHECK_NEXT(a_empty_result, empty_victim, m_axis_tvalid && !m_axis_tuser, "empty victim lost")
    `CHECK_SAME(a_victim_listed, state_reg == ST_EXEC && op_reg == OP_VICTIM, rd_prev_reg[IDX_W], "oldest page not listed")
    `CHECK_NEXT(a_count_hold, state_reg != ST_EXEC, $stable(count_reg), "count moved outside update")

endmodule
